FILE: rtl/artp_pkg.sv
// Shared types and constants for the record-then-playback engine.
// Used by the top level and the statistics unit.
package artp_pkg;

	localparam int STORE_DEPTH = 131072;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 12;
	localparam int RATE_W     = 16;
	localparam int SECS_W     = 8;
	localparam int CFG_W      = 16;
	localparam int TGT_PROD_W = RATE_W + SECS_W;
	localparam int MUL_W      = SAMPLE_W + GAIN_W + 1;
	localparam int QUOT_W     = MUL_W - GAIN_FRAC;
	localparam int COUNT_W    = 18;
	localparam int SUM_W      = 33;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	localparam logic [SECS_W-1:0] DEFAULT_SECONDS = SECS_W'(5);
	localparam logic [GAIN_W-1:0] GAIN_UNITY      = GAIN_W'(4096);
	localparam logic [RATE_W-1:0] RATE_RESET      = RATE_W'(16000);
	localparam logic [SECS_W-1:0] MAX_SECS_RESET  = SECS_W'(5);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REQ_RECORD = 2'd0,
		REQ_REPLAY = 2'd1,
		REQ_FRAME  = 2'd2,
		REQ_SLOT   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		REG_RECORD_GAIN   = 2'd0,
		REG_PLAYBACK_GAIN = 2'd1,
		REG_SAMPLE_RATE   = 2'd2,
		REG_MAX_SECONDS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                 req_type;
		logic [SECS_W-1:0]          seconds;
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} req_t;

	typedef struct packed {
		logic [1:0]                 mode_now;
		logic                       sample_valid;
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       output_on;
		logic [COUNT_W-1:0]         filled_count;
		logic signed [SAMPLE_W-1:0] min_left;
		logic signed [SAMPLE_W-1:0] max_left;
		logic signed [SAMPLE_W-1:0] min_right;
		logic signed [SAMPLE_W-1:0] max_right;
		logic signed [SAMPLE_W-1:0] min_mono;
		logic signed [SAMPLE_W-1:0] max_mono;
		logic [SUM_W-1:0]           sum_abs_mono;
	} rsp_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] min_l;
		logic signed [SAMPLE_W-1:0] max_l;
		logic signed [SAMPLE_W-1:0] min_r;
		logic signed [SAMPLE_W-1:0] max_r;
		logic signed [SAMPLE_W-1:0] min_m;
		logic signed [SAMPLE_W-1:0] max_m;
		logic [SUM_W-1:0]           sum;
	} stat_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic store;
	} stat_ctl_t;

	typedef struct packed {
		logic              store;
		logic              play;
		logic              clr;
		mode_t             mode;
		logic [FILL_W-1:0] filled;
		logic [ADDR_W-1:0] waddr;
	} ctl_t;

	localparam stat_t STAT_RESET = '{
		min_l: SAMPLE_W'(SAMPLE_MAX), max_l: SAMPLE_W'(SAMPLE_MIN),
		min_r: SAMPLE_W'(SAMPLE_MAX), max_r: SAMPLE_W'(SAMPLE_MIN),
		min_m: SAMPLE_W'(SAMPLE_MAX), max_m: SAMPLE_W'(SAMPLE_MIN),
		sum:   '0
	};

endpackage

FILE: rtl/artp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies; read data holds until the next read.
module artp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/artp_stats.sv
// Recording statistics: extremes of left, right and stored mono, and sum of |mono|.
// Depends on artp_pkg.
module artp_stats (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  artp_pkg::stat_ctl_t                  ctl,
	input  logic signed [artp_pkg::SAMPLE_W-1:0] left,
	input  logic signed [artp_pkg::SAMPLE_W-1:0] right,
	input  logic signed [artp_pkg::SAMPLE_W-1:0] mono,
	output artp_pkg::stat_t                      stats_next
);
	import artp_pkg::*;

	stat_t              stats_q;
	logic [SAMPLE_W:0]  mono_abs;
	logic [SUM_W:0]     sum_ext;

	assign mono_abs = mono[SAMPLE_W-1] ? ((SAMPLE_W + 1)'(0) - {mono[SAMPLE_W-1], mono})
		: {1'b0, mono};
	assign sum_ext  = {1'b0, stats_q.sum} + (SUM_W + 1)'(mono_abs);

	always_comb begin
		stats_next = stats_q;
		if (ctl.clr) begin
			stats_next = STAT_RESET;
		end else if (ctl.store) begin
			if (left < stats_q.min_l) stats_next.min_l = left;
			if (left > stats_q.max_l) stats_next.max_l = left;
			if (right < stats_q.min_r) stats_next.min_r = right;
			if (right > stats_q.max_r) stats_next.max_r = right;
			if (mono < stats_q.min_m) stats_next.min_m = mono;
			if (mono > stats_q.max_m) stats_next.max_m = mono;
			stats_next.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= STAT_RESET;
		end else if (ctl.upd) begin
			stats_q <= stats_next;
		end
	end

endmodule

FILE: rtl/audio_record_then_playback.sv
// Record-then-playback engine: idle/record/play control over a mono sample store.
// Depends on artp_pkg, artp_ram and artp_stats.
//
//   channel | direction | handshake          | beat
//   req     | in        | req_valid/req_stall | req_t: command, frame or slot
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t: one per req beat
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One req beat per cycle unless req is stalled; its rsp beat passes through
// store read, gain multiply, round and saturate, then statistics and store write.
// A playback slot is held while a stored frame is still in the pipeline on
// its way to the store. No clearing pass after reset: the store is only read
// below the fill count. A stalled rsp holds the whole pipeline and stalls req.
module audio_record_then_playback (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  artp_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output artp_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  artp_pkg::reg_idx_t             cfg_index,
	input  logic [artp_pkg::CFG_W-1:0]     cfg_data
);
	import artp_pkg::*;

	logic [GAIN_W-1:0] rgain_q, pgain_q;
	logic [RATE_W-1:0] rate_q;
	logic [SECS_W-1:0] max_secs_q;

	mode_t             mode_q, mode_d;
	logic [FILL_W-1:0] filled_q, filled_d, target_q, target_d, pos_q, pos_d;
	logic [FILL_W-1:0] fill_inc, pos_inc;
	logic              store_ok, play_ok;

	logic [SECS_W-1:0]     secs_req, secs_eff;
	logic [TGT_PROD_W-1:0] tgt_prod;

	logic advance, hazard, accept;

	ctl_t ctl_in, ctl_s1, ctl_s2, ctl_s3;
	logic v_s1, v_s2, v_s3;

	logic [SAMPLE_W:0]          diff, diff_adj;
	logic signed [SAMPLE_W-1:0] mono_in, mono_s1;
	logic signed [SAMPLE_W-1:0] l_s1, r_s1, l_s2, r_s2, l_s3, r_s3;

	logic signed [SAMPLE_W-1:0] mul_a;
	logic signed [GAIN_W:0]     mul_b;
	logic signed [MUL_W-1:0]    mul_p, prod_s2;
	logic [QUOT_W-1:0]          quot_bits;
	logic signed [QUOT_W-1:0]   quot;
	logic signed [SAMPLE_W-1:0] sat_val, val_s3;

	localparam logic signed [QUOT_W-1:0] QUOT_HI = QUOT_W'(SAMPLE_MAX);
	localparam logic signed [QUOT_W-1:0] QUOT_LO = QUOT_W'(SAMPLE_MIN);

	logic                ram_we, ram_re;
	logic [SAMPLE_W-1:0] ram_rdata;

	stat_ctl_t stat_ctl;
	stat_t     stats_nx;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgain_q    <= GAIN_UNITY;
			pgain_q    <= GAIN_UNITY;
			rate_q     <= RATE_RESET;
			max_secs_q <= MAX_SECS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RECORD_GAIN:   rgain_q    <= cfg_data[GAIN_W-1:0];
				REG_PLAYBACK_GAIN: pgain_q    <= cfg_data[GAIN_W-1:0];
				REG_SAMPLE_RATE:   rate_q     <= cfg_data[RATE_W-1:0];
				REG_MAX_SECONDS:   max_secs_q <= cfg_data[SECS_W-1:0];
			endcase
		end
	end

	// handshake
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign hazard    = (req.req_type == REQ_SLOT)
		&& ((v_s1 && ctl_s1.store) || (v_s2 && ctl_s2.store) || (v_s3 && ctl_s3.store));
	assign req_stall = !advance || hazard;
	assign accept    = req_valid && !req_stall;

	// control decisions at acceptance
	assign store_ok = (mode_q == MODE_REC) && (filled_q < target_q);
	assign play_ok  = (mode_q == MODE_PLAY) && (pos_q < filled_q);
	assign fill_inc = filled_q + FILL_W'(store_ok);
	assign pos_inc  = pos_q + FILL_W'(1);

	assign secs_req = (req.seconds == '0) ? DEFAULT_SECONDS : req.seconds;
	assign secs_eff = (secs_req > max_secs_q) ? max_secs_q : secs_req;
	assign tgt_prod = TGT_PROD_W'(rate_q) * TGT_PROD_W'(secs_eff);

	always_comb begin
		mode_d = mode_q;
		unique case (req_kind_t'(req.req_type))
			REQ_RECORD: begin
				if (mode_q == MODE_IDLE) mode_d = MODE_REC;
			end
			REQ_REPLAY: begin
				if (mode_q == MODE_IDLE && filled_q != '0) mode_d = MODE_PLAY;
			end
			REQ_FRAME: begin
				if (mode_q == MODE_REC && fill_inc >= target_q) begin
					mode_d = (fill_inc != '0) ? MODE_PLAY : MODE_IDLE;
				end
			end
			REQ_SLOT: begin
				if (mode_q == MODE_PLAY && (!play_ok || pos_inc >= filled_q)) begin
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		filled_d      = filled_q;
		target_d      = target_q;
		pos_d         = pos_q;
		ctl_in.store  = 1'b0;
		ctl_in.play   = 1'b0;
		ctl_in.clr    = 1'b0;
		ram_re        = 1'b0;
		unique case (req_kind_t'(req.req_type))
			REQ_RECORD: begin
				if (mode_q == MODE_IDLE) begin
					target_d   = (tgt_prod > TGT_PROD_W'(STORE_DEPTH)) ? FILL_W'(STORE_DEPTH)
						: FILL_W'(tgt_prod);
					filled_d   = '0;
					ctl_in.clr = 1'b1;
				end
			end
			REQ_REPLAY: begin
				if (mode_q == MODE_IDLE && filled_q != '0) pos_d = '0;
			end
			REQ_FRAME: begin
				if (mode_q == MODE_REC) begin
					filled_d     = fill_inc;
					ctl_in.store = store_ok;
					if (fill_inc >= target_q) pos_d = '0;
				end
			end
			REQ_SLOT: begin
				if (play_ok) begin
					pos_d       = pos_inc;
					ctl_in.play = 1'b1;
					ram_re      = accept;
				end
			end
		endcase
		ctl_in.mode   = mode_d;
		ctl_in.filled = filled_d;
		ctl_in.waddr  = filled_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			filled_q <= '0;
			target_q <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			filled_q <= filled_d;
			target_q <= target_d;
			pos_q    <= pos_d;
		end
	end

	// fold to mono, truncated toward zero
	assign diff     = {req.left_in[SAMPLE_W-1], req.left_in}
		- {req.right_in[SAMPLE_W-1], req.right_in};
	assign diff_adj = diff + (SAMPLE_W + 1)'(diff[SAMPLE_W]);
	assign mono_in  = diff_adj[SAMPLE_W:1];

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			rsp_valid_q <= v_s3;
		end
	end

	// shared gain multiplier
	assign mul_a = ctl_s1.play ? $signed(ram_rdata) : mono_s1;
	assign mul_b = $signed({1'b0, ctl_s1.play ? pgain_q : rgain_q});
	assign mul_p = mul_a * mul_b;

	// divide by 4096 toward zero, then saturate
	assign quot_bits = prod_s2[MUL_W-1:GAIN_FRAC]
		+ QUOT_W'(prod_s2[MUL_W-1] && (prod_s2[GAIN_FRAC-1:0] != '0));
	assign quot      = $signed(quot_bits);
	assign sat_val   = (quot > QUOT_HI) ? SAMPLE_W'(SAMPLE_MAX)
		: (quot < QUOT_LO) ? SAMPLE_W'(SAMPLE_MIN) : quot[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s1  <= ctl_in;
			mono_s1 <= mono_in;
			l_s1    <= req.left_in;
			r_s1    <= req.right_in;
			ctl_s2  <= ctl_s1;
			prod_s2 <= mul_p;
			l_s2    <= l_s1;
			r_s2    <= r_s1;
			ctl_s3  <= ctl_s2;
			val_s3  <= sat_val;
			l_s3    <= l_s2;
			r_s3    <= r_s2;
		end
	end

	assign ram_we = advance && v_s3 && ctl_s3.store;

	artp_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctl_s3.waddr),
		.wdata (val_s3),
		.re    (ram_re),
		.raddr (pos_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign stat_ctl.upd   = advance && v_s3;
	assign stat_ctl.clr   = v_s3 && ctl_s3.clr;
	assign stat_ctl.store = v_s3 && ctl_s3.store;

	artp_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (stat_ctl),
		.left       (l_s3),
		.right      (r_s3),
		.mono       (val_s3),
		.stats_next (stats_nx)
	);

	// response register
	always_ff @(posedge clk) begin
		if (advance && v_s3) begin
			rsp_q.mode_now     <= ctl_s3.mode;
			rsp_q.sample_valid <= ctl_s3.play;
			rsp_q.sample_out   <= ctl_s3.play ? val_s3 : '0;
			rsp_q.output_on    <= (ctl_s3.mode == MODE_PLAY);
			rsp_q.filled_count <= COUNT_W'(ctl_s3.filled);
			rsp_q.min_left     <= stats_nx.min_l;
			rsp_q.max_left     <= stats_nx.max_l;
			rsp_q.min_right    <= stats_nx.min_r;
			rsp_q.max_right    <= stats_nx.max_r;
			rsp_q.min_mono     <= stats_nx.min_m;
			rsp_q.max_mono     <= stats_nx.max_m;
			rsp_q.sum_abs_mono <= stats_nx.sum;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_REC |-> filled_q <= target_q)
		else $error("fill count passed recording target");

	a_play_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PLAY |-> pos_q < filled_q)
		else $error("playing with position at or past fill count");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("store read issued while a write is pending");

	a_target_cap: assert property (@(posedge clk) disable iff (!arst_n)
		target_q <= FILL_W'(STORE_DEPTH))
		else $error("target exceeds store depth");

endmodule
